// ===== hdl/tea_pkg.sv =====
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and the round mixing function of the TEA cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

  // golden-ratio round constant
  localparam logic [31:0] TEA_DELTA = 32'h9e3779b9;

  // width of the key register index
  localparam int unsigned KEY_IDX_W = 2;

  // operation carried by each beat
  typedef enum logic {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_t;

  // key register indexes
  typedef enum logic [KEY_IDX_W-1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } key_idx_t;

  // the four 32-bit key words
  typedef logic [3:0][31:0] key_t;

  // block moving down the round pipeline
  typedef struct packed {
    op_t         op;
    logic [31:0] y;
    logic [31:0] z;
  } tea_item_t;

  // result block held at the output
  typedef struct packed {
    logic [31:0] y;
    logic [31:0] z;
  } tea_blk_t;

  // round mixing function, all sums wrap at 32 bits
  function automatic logic [31:0] tea_mix(input logic [31:0] w,
                                          input logic [31:0] sum,
                                          input logic [31:0] kl,
                                          input logic [31:0] kr);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = (w << 4) + kl;
    b = w + sum;
    c = (w >> 5) + kr;
    return a ^ b ^ c;
  endfunction

endpackage

// ===== hdl/tea_in_if.sv =====
// ----------------------------------------------------------------------------
// tea_in_if
// Input channel: one plaintext or ciphertext block with its operation bit.
// ----------------------------------------------------------------------------
interface tea_in_if;

  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] word_y;
  logic [31:0] word_z;

  modport source (output valid, output kind, output word_y, output word_z, input ready);
  modport sink   (input valid, input kind, input word_y, input word_z, output ready);

endinterface

// ===== hdl/tea_out_if.sv =====
// ----------------------------------------------------------------------------
// tea_out_if
// Output channel: one result block.
// ----------------------------------------------------------------------------
interface tea_out_if;

  logic        valid;
  logic        ready;
  logic [31:0] out_y;
  logic [31:0] out_z;

  modport source (output valid, output out_y, output out_z, input ready);
  modport sink   (input valid, input out_y, input out_z, output ready);

endinterface

// ===== hdl/tea_stage.sv =====
// ----------------------------------------------------------------------------
// tea_stage
// One half round of TEA as a register stage. The first half of a round
// updates y when encrypting and z when decrypting; the second half updates
// the other word. The round sum for each direction is fixed per stage.
// ----------------------------------------------------------------------------
module tea_stage
  import tea_pkg::*;
#(
  parameter logic [31:0] SUM_ENC    = 32'h0,
  parameter logic [31:0] SUM_DEC    = 32'h0,
  parameter bit          FIRST_HALF = 1'b1
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  tea_item_t in_item,
  input  key_t      key,
  output logic      out_valid,
  output tea_item_t out_item
);

  tea_item_t item_next;

  // half-round update
  always_comb begin
    item_next = in_item;
    if (FIRST_HALF) begin
      if (in_item.op == OP_ENC) begin
        item_next.y = in_item.y + tea_mix(in_item.z, SUM_ENC, key[0], key[1]);
      end else begin
        item_next.z = in_item.z - tea_mix(in_item.y, SUM_DEC, key[2], key[3]);
      end
    end else begin
      if (in_item.op == OP_ENC) begin
        item_next.z = in_item.z + tea_mix(in_item.y, SUM_ENC, key[2], key[3]);
      end else begin
        item_next.y = in_item.y - tea_mix(in_item.z, SUM_DEC, key[0], key[1]);
      end
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== hdl/tea_out_buf.sv =====
// ----------------------------------------------------------------------------
// tea_out_buf
// Two-entry output buffer. Absorbs the beat leaving the pipeline while the
// consumer stalls, and reports full from a register so the input side never
// waits on the output ready combinationally.
// ----------------------------------------------------------------------------
module tea_out_buf
  import tea_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tea_blk_t  push_blk,
  output logic      full,
  tea_out_if.source ch
);

  tea_blk_t    ent [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop      = ch.valid && ch.ready;
  assign full     = (count == 2'd2);
  assign ch.valid = (count != 2'd0);
  assign ch.out_y = ent[rd_ptr].y;
  assign ch.out_z = ent[rd_ptr].z;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_blk;
    end
  end

endmodule

// ===== hdl/tea_block_cipher.sv =====
// ----------------------------------------------------------------------------
// tea_block_cipher
// TEA encrypt / decrypt of 64-bit blocks with a 128-bit key, one half round
// per pipeline stage.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  din       in   valid / ready     kind, word_y, word_z
//  dout      out  valid / ready     out_y, out_z
//  cfg       in   cfg_we            cfg_index, cfg_data (key words 0..3)
//
//  one block accepted per cycle while din.ready is high; each passes through
//  the 2*ROUNDS half-round stage registers (the first loads at the accept
//  edge) and then the output buffer register before it shows on dout. reset is
//  synchronous and clears the key words, all stage valid bits and the output
//  buffer. a stall on dout fills the two-entry output buffer, then freezes
//  the whole pipeline and drops din.ready.
// ----------------------------------------------------------------------------
module tea_block_cipher
  import tea_pkg::*;
#(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [KEY_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  tea_in_if.sink               din,
  tea_out_if.source            dout
);

  localparam int unsigned Stages = 2 * ROUNDS;

  key_t      key;
  logic      en;
  logic      buf_full;
  logic      stg_valid [Stages+1];
  tea_item_t stg_item  [Stages+1];
  tea_blk_t  res_blk;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      case (key_idx_t'(cfg_index))
        REG_KEY0: key[0] <= cfg_data;
        REG_KEY1: key[1] <= cfg_data;
        REG_KEY2: key[2] <= cfg_data;
        REG_KEY3: key[3] <= cfg_data;
        default:  key    <= key;
      endcase
    end
  end

  // pipeline moves unless a finished beat has nowhere to go
  assign en        = !(buf_full && stg_valid[Stages]);
  assign din.ready = en;

  // pipeline entry
  assign stg_valid[0]   = din.valid;
  assign stg_item[0].op = op_t'(din.kind);
  assign stg_item[0].y  = din.word_y;
  assign stg_item[0].z  = din.word_z;

  // half-round stages
  for (genvar s = 0; s < Stages; s++) begin : g_stage
    localparam int unsigned  Rnd     = s / 2;
    localparam logic [63:0]  ProdEnc = 64'(TEA_DELTA) * 64'(Rnd + 1);
    localparam logic [63:0]  ProdDec = 64'(TEA_DELTA) * 64'(ROUNDS - Rnd);

    tea_stage #(
      .SUM_ENC    (ProdEnc[31:0]),
      .SUM_DEC    (ProdDec[31:0]),
      .FIRST_HALF ((s % 2) == 0)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stg_valid[s]),
      .in_item   (stg_item[s]),
      .key       (key),
      .out_valid (stg_valid[s+1]),
      .out_item  (stg_item[s+1])
    );
  end

  // result beat into the output buffer
  assign res_blk.y = stg_item[Stages].y;
  assign res_blk.z = stg_item[Stages].z;

  tea_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (en && stg_valid[Stages]),
    .push_blk (res_blk),
    .full     (buf_full),
    .ch       (dout)
  );

endmodule

// ===== hdl/tea_checker.sv =====
// ----------------------------------------------------------------------------
// tea_checker
// Port-level checks of the TEA block: beat accounting across the pipeline,
// back pressure and output hold.
// ----------------------------------------------------------------------------
module tea_checker
  import tea_pkg::*;
#(
  parameter int unsigned ROUNDS = 32
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_y,
  input logic [31:0] out_z
);

  localparam int unsigned MaxOut = 2 * ROUNDS + 2;
  localparam int unsigned CntW   = $clog2(MaxOut + 2);

  logic [CntW-1:0] outstanding;
  logic            acc_in;
  logic            acc_out;

  assign acc_in  = in_valid && in_ready;
  assign acc_out = out_valid && out_ready;

  // beats accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (acc_in && !acc_out) begin
      outstanding <= outstanding + CntW'(1);
    end else if (acc_out && !acc_in) begin
      outstanding <= outstanding - CntW'(1);
    end
  end

  // nothing shows on the output after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // every result belongs to an accepted beat
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != '0)
    else $error("result with no beat outstanding");

  // pipeline plus buffer never holds more than its depth
  a_depth: assert property (@(posedge clk) disable iff (rst)
    outstanding <= CntW'(MaxOut))
    else $error("more beats outstanding than the pipeline holds");

  // input back pressure only while a result waits
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_y) && $stable(out_z))
    else $error("stalled result changed");

endmodule

bind tea_block_cipher tea_checker #(.ROUNDS(ROUNDS)) u_tea_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_y     (dout.out_y),
  .out_z     (dout.out_z)
);

// ===== tb/sv/tea_block_cipher_test.sv =====
// ----------------------------------------------------------------------------
// tea_block_cipher_test
// Self-checking bench for the TEA block cipher. Blocks go in on din with
// random gaps and come back on dout against random back-pressure. Every
// accepted block is run through a local 32-round TEA model under the key last
// written, and each result beat is compared with the oldest prediction. A
// short vector table comes first, then random traffic over several key
// settings, including one long output stall that backs the pipeline up.
// ----------------------------------------------------------------------------
module tea_block_cipher_test
  import tea_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned LATENCY = 2 * ROUNDS + 1;
  localparam int unsigned SINK_HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned MAX_REPORTS = 10;

  // one row of the vector table
  typedef struct {
    op_t         op;
    logic [31:0] y;
    logic [31:0] z;
    bit          typed;
    tea_blk_t    want;
  } vector_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [KEY_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  tea_in_if  din ();
  tea_out_if dout ();

  tea_block_cipher #(
    .ROUNDS(ROUNDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .din(din),
    .dout(dout)
  );

  key_t     key_shadow;
  tea_blk_t pending_blocks [$];
  tea_blk_t recent_cipher;
  int       mismatches;
  int       cycle_count;
  bit       hold_req;
  bit       hold_ack;
  bit       no_idle;

  // zero-key rows carry the published all-zero TEA vector
  vector_row_t vectors [16] = '{
    '{OP_ENC, 32'h00000000, 32'h00000000, 1'b1, 64'h41ea3a0a_94baa940},
    '{OP_DEC, 32'h41ea3a0a, 32'h94baa940, 1'b1, 64'h00000000_00000000},
    '{OP_ENC, 32'hffffffff, 32'hffffffff, 1'b0, '0},
    '{OP_DEC, 32'hffffffff, 32'hffffffff, 1'b0, '0},
    '{OP_DEC, 32'h00000000, 32'h00000000, 1'b0, '0},
    '{OP_ENC, 32'h00000000, 32'hffffffff, 1'b0, '0},
    '{OP_ENC, 32'hffffffff, 32'h00000000, 1'b0, '0},
    '{OP_DEC, 32'h00000000, 32'hffffffff, 1'b0, '0},
    '{OP_DEC, 32'hffffffff, 32'h00000000, 1'b0, '0},
    '{OP_ENC, 32'h80000000, 32'h00000001, 1'b0, '0},
    '{OP_ENC, 32'h00000001, 32'h80000000, 1'b0, '0},
    '{OP_ENC, 32'haaaaaaaa, 32'h55555555, 1'b0, '0},
    '{OP_DEC, 32'h55555555, 32'haaaaaaaa, 1'b0, '0},
    '{OP_ENC, 32'h9e3779b9, 32'hc6ef3720, 1'b0, '0},
    '{OP_DEC, 32'h9e3779b9, 32'hc6ef3720, 1'b0, '0},
    '{OP_ENC, 32'h0000001f, 32'hf8000000, 1'b0, '0}
  };

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one TEA half-round mix, all sums wrap at 32 bits
  function automatic logic [31:0] round_mix(input logic [31:0] w, input logic [31:0] sum,
                                            input logic [31:0] kl, input logic [31:0] kr);
    return ((w << 4) + kl) ^ (w + sum) ^ ((w >> 5) + kr);
  endfunction

  // full 32-round TEA on one block
  function automatic tea_blk_t tea_predict(input op_t op, input logic [31:0] y_in,
                                           input logic [31:0] z_in, input key_t key);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    tea_blk_t    blk;
    y = y_in;
    z = z_in;
    if (op == OP_ENC) begin
      sum = '0;
      for (int r = 0; r < ROUNDS; r++) begin
        sum = sum + TEA_DELTA;
        y = y + round_mix(z, sum, key[REG_KEY0], key[REG_KEY1]);
        z = z + round_mix(y, sum, key[REG_KEY2], key[REG_KEY3]);
      end
    end else begin
      sum = 32'(TEA_DELTA * ROUNDS);
      for (int r = 0; r < ROUNDS; r++) begin
        z = z - round_mix(y, sum, key[REG_KEY2], key[REG_KEY3]);
        y = y - round_mix(z, sum, key[REG_KEY0], key[REG_KEY1]);
        sum = sum - TEA_DELTA;
      end
    end
    blk.y = y;
    blk.z = z;
    return blk;
  endfunction

  // idle length: mostly none, some short, a few long, with calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // data word biased toward the edges
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 32'h00000000;
    if (r == 1) return 32'hffffffff;
    if (r == 2) return 32'h1 << $urandom_range(0, 31);
    return $urandom;
  endfunction

  // offer one beat on din, record its prediction at the accept edge
  int src_calm;
  task automatic send_block(input op_t op, input logic [31:0] y, input logic [31:0] z,
                            input bit typed, input tea_blk_t want);
    int       gap;
    tea_blk_t blk;
    gap = no_idle ? 0 : pick_gap(src_calm);
    if (gap > 0) begin
      din.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    din.valid  <= 1'b1;
    din.kind   <= op;
    din.word_y <= y;
    din.word_z <= z;
    do @(posedge clk); while (!din.ready);
    blk = typed ? want : tea_predict(op, y, z, key_shadow);
    pending_blocks.push_back(blk);
    if (op == OP_ENC) recent_cipher = blk;
    @(negedge clk);
  endtask

  // sender pauses until every result is back
  task automatic drain();
    din.valid <= 1'b0;
    @(negedge clk);
    while (pending_blocks.size() != 0) @(negedge clk);
  endtask

  // one key register write, pipeline idle
  task automatic write_key_word(input key_idx_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    key_shadow[idx] = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_key(input key_t k);
    key_idx_t idx;
    idx = idx.first();
    repeat (idx.num()) begin
      write_key_word(idx, k[idx]);
      idx = idx.next();
    end
  endtask

  task automatic run_vectors(input bit use_typed);
    foreach (vectors[i]) begin
      send_block(vectors[i].op, vectors[i].y, vectors[i].z,
                 use_typed && vectors[i].typed, vectors[i].want);
    end
  endtask

  // random blocks, some decrypting the latest ciphertext
  task automatic run_random(input int n);
    int          pick;
    op_t         op;
    logic [31:0] y;
    logic [31:0] z;
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        op = OP_DEC;
        y  = recent_cipher.y;
        z  = recent_cipher.z;
      end else begin
        op = op_t'($urandom_range(0, 1));
        y  = pick_word();
        z  = pick_word();
      end
      send_block(op, y, z, 1'b0, '0);
    end
  endtask

  // receiver side: random stalls plus one long requested hold-off
  initial begin : sink_side
    int stall;
    int calm;
    int held;
    stall = 0;
    calm = 0;
    held = 0;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_ack) begin
        dout.ready <= 1'b0;
        held++;
        if (held >= SINK_HOLD_CYCLES) hold_ack = 1'b1;
      end else if (stall > 0) begin
        dout.ready <= 1'b0;
        stall--;
      end else begin
        dout.ready <= 1'b1;
        if (!no_idle) stall = pick_gap(calm);
      end
      @(negedge clk);
    end
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    if (!rst && dout.valid && dout.ready) begin
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected beat: out_y %h out_z %h", dout.out_y, dout.out_z);
      end else begin
        tea_blk_t want;
        want = pending_blocks.pop_front();
        if (dout.out_y !== want.y || dout.out_z !== want.z) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: out_y exp %h got %h, out_z exp %h got %h",
                     want.y, dout.out_y, want.z, dout.out_z);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tea_block_cipher_test: done, errors");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = REG_KEY0;
    cfg_data   = '0;
    din.valid  = 1'b0;
    din.kind   = OP_ENC;
    din.word_y = '0;
    din.word_z = '0;
    dout.ready = 1'b0;
    key_shadow = '0;
    recent_cipher = '0;
    mismatches = 0;
    cycle_count = 0;
    hold_req   = 1'b0;
    hold_ack   = 1'b0;
    no_idle    = 1'b0;
    src_calm   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // key never written: reset key of zero
    run_vectors(1'b1);
    run_random(20);
    hold_req = 1'b1;
    run_random(80);
    drain();

    // all-ones key
    load_key({4{32'hffffffff}});
    run_vectors(1'b0);
    run_random(100);
    drain();

    // alternating patterns
    load_key({32'hffffffff, 32'h00000000, 32'h55555555, 32'haaaaaaaa});
    run_random(80);
    drain();

    // random key, then single words changed alone
    load_key({$urandom, $urandom, $urandom, $urandom});
    run_random(80);
    drain();
    write_key_word(REG_KEY1, $urandom);
    run_random(50);
    drain();
    write_key_word(REG_KEY3, $urandom);
    run_random(50);
    drain();

    // random key at full rate on both sides
    load_key({$urandom, $urandom, $urandom, $urandom});
    no_idle = 1'b1;
    run_random(150);
    drain();

    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && pending_blocks.size() == 0) begin
      $display("tea_block_cipher_test: done, clean");
    end else begin
      $display("tea_block_cipher_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tea_pkg.sv
hdl/tea_in_if.sv
hdl/tea_out_if.sv
hdl/tea_stage.sv
hdl/tea_out_buf.sv
hdl/tea_block_cipher.sv
hdl/tea_checker.sv
tb/sv/tea_block_cipher_test.sv
